@@ src/c1dhw_pkg.sv @@
package c1dhw_pkg;

   localparam logic [1:0] REQ_SAMPLE  = 2'd0;
   localparam logic [1:0] REQ_WEIGHT  = 2'd1;
   localparam logic [1:0] REQ_BIAS    = 2'd2;
   localparam logic [1:0] REQ_COMPUTE = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_CFG   = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [2:0] CSR_IN_CHANNELS  = 3'd0;
   localparam logic [2:0] CSR_IN_WIDTH     = 3'd1;
   localparam logic [2:0] CSR_OUT_CHANNELS = 3'd2;
   localparam logic [2:0] CSR_KERNEL_TAPS  = 3'd3;
   localparam logic [2:0] CSR_STEP_SIZE    = 3'd4;
   localparam logic [2:0] CSR_PAD_AMOUNT   = 3'd5;
   localparam logic [2:0] CSR_BIAS_ENABLE  = 3'd6;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [10:0]        load_index;
      logic signed [15:0] sample_value;
      logic [15:0]        half_bits;
      logic [2:0]         want_channel;
      logic [8:0]         want_position;
   } req_type_t_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [8:0]         out_count;
      logic [1:0]         status;
   } rsp_type_t_type;

   // binary16 to signed Q4.12, round half away from zero, saturating
   function automatic logic [15:0] half_to_q412(input logic [15:0] h);
      logic        sgn;
      logic [4:0]  e;
      logic [9:0]  m;
      logic [10:0] sig;
      logic [4:0]  ee;
      logic [4:0]  sh;
      logic [16:0] mag;
      logic [27:0] wide;
      logic [16:0] res;
      sgn = h[15];
      e   = h[14:10];
      m   = h[9:0];
      sig = (e != 5'd0) ? {1'b1, m} : {1'b0, m};
      ee  = (e != 5'd0) ? e : 5'd1;
      mag = 17'd0;
      wide = 28'd0;
      sh = 5'd0;
      if (e == 5'd31) begin
         mag = (m != 10'd0) ? 17'd0 : 17'h10000;
      end else if (ee >= 5'd13) begin
         sh = ee - 5'd13;
         wide = {17'd0, sig} << sh;
         mag = (wide[27:17] != 11'd0) ? 17'h10000 : wide[16:0];
      end else begin
         sh = 5'd13 - ee;
         wide = ({17'd0, sig} + (28'd1 << (sh - 5'd1))) >> sh;
         mag = wide[16:0];
      end
      if (sgn) begin
         if (mag > 17'd32768) mag = 17'd32768;
         res = 17'd0 - mag;
      end else begin
         if (mag > 17'd32767) mag = 17'd32767;
         res = mag;
      end
      if (e == 5'd31 && m != 10'd0) res = 17'd0;
      return res[15:0];
   endfunction

endpackage

@@ src/c1dhw_if.sv @@
interface c1dhw_req_if;
   import c1dhw_pkg::*;
   logic           valid;
   logic           ready;
   req_type_t_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface c1dhw_rsp_if;
   import c1dhw_pkg::*;
   logic           valid;
   logic           ready;
   rsp_type_t_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/c1dhw_mac.sv @@
module c1dhw_mac (
   input  logic               clock,
   input  logic               clear,
   input  logic               bias_add,
   input  logic               tap_add,
   input  logic signed [15:0] a_value,
   input  logic signed [15:0] b_value,
   output logic signed [43:0] acc_value
);
   import c1dhw_pkg::*;

   logic signed [31:0] prod_ff;
   logic               prod_vld_ff;
   logic signed [43:0] acc_ff;
   logic signed [43:0] acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (clear) acc_in = 44'sd0;
      else if (prod_vld_ff) acc_in = acc_ff + 44'(prod_ff);
      else if (bias_add) acc_in = acc_ff + (44'(b_value) <<< 8);
   end

   always_ff @(posedge clock) begin
      prod_ff     <= a_value * b_value;
      prod_vld_ff <= tap_add & ~clear;
      acc_ff      <= acc_in;
   end

   assign acc_value = acc_ff;
endmodule

@@ src/conv1d_half_weights_top.sv @@
// Multi-channel 1-D convolution with stride and zero padding.
// req channel: item kinds are sample load, weight load (binary16), bias load
// (binary16) and compute. A load writes at most one entry, with no response.
// A compute item returns one rsp item: Q16.16 result, produced width, status.
// A load is accepted and lands in its store on the next edge;
// loads can follow each other with no gap.
// A compute item finds the produced width by one subtract per cycle, then
// one store read per tap feeds the single shared multiply-accumulate. A bad
// configuration, or a request out of range once the width is found, returns
// a status with no taps worked.
// One item is in work at a time; req_ready drops while an item is worked.
// The response sits in an output register; a stalled receiver holds it and
// the block accepts the next item meanwhile, stalling only when a new
// response would need the register.
// Reset (synchronous, active high) sets the registers to their defaults
// and clears control state; the stores are undefined until written.
// csr port: write enable, register index, data; write only while idle.
module conv1d_half_weights_top #(
   parameter int MAX_IN_CHANNELS  = 8,
   parameter int MAX_OUT_CHANNELS = 8,
   parameter int MAX_WIDTH        = 256,
   parameter int MAX_KERNEL       = 16
) (
   input  logic        clock,
   input  logic        reset,
   c1dhw_req_if.sink   req,
   c1dhw_rsp_if.source rsp,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import c1dhw_pkg::*;

   localparam int SDEPTH = MAX_IN_CHANNELS * MAX_WIDTH;
   localparam int WDEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL;
   localparam int SAW = $clog2(SDEPTH);
   localparam int WAW = $clog2(WDEPTH);
   localparam int BAW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHK   = 3'd1;
   localparam logic [2:0] S_TAP   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_BIAS  = 3'd4;
   localparam logic [2:0] S_FIN   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;
   localparam logic [2:0] S_DIV   = 3'd7;

   logic [3:0] ic_ff, oc_ff, step_ff, pad_ff;
   logic [8:0] width_ff;
   logic [4:0] taps_ff;
   logic       bias_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ic_ff <= 4'd1; width_ff <= 9'd1; oc_ff <= 4'd1; taps_ff <= 5'd1;
         step_ff <= 4'd1; pad_ff <= 4'd0; bias_en_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IN_CHANNELS:  ic_ff <= csr_data[3:0];
            CSR_IN_WIDTH:     width_ff <= csr_data;
            CSR_OUT_CHANNELS: oc_ff <= csr_data[3:0];
            CSR_KERNEL_TAPS:  taps_ff <= csr_data[4:0];
            CSR_STEP_SIZE:    step_ff <= csr_data[3:0];
            CSR_PAD_AMOUNT:   pad_ff <= csr_data[3:0];
            CSR_BIAS_ENABLE:  bias_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [15:0] sample_mem [SDEPTH];
   logic [15:0] weight_mem [WDEPTH];
   logic [15:0] bias_mem [MAX_OUT_CHANNELS];
   logic [15:0] s_rd_ff, w_rd_ff, b_rd_ff;

   logic [2:0]  state_ff, state_in;
   req_type_t_type item_ff;
   logic [15:0] conv_ff;
   logic        load_ff;

   logic [9:0]  padded;
   logic        cfg_bad;
   logic [9:0]  prod_ff;       // produced width - 1 (quotient), built by repeated subtract
   logic [9:0]  rem_ff;
   logic [1:0]  stat_ff;

   logic [3:0]  ci_ff;         // input channel
   logic [4:0]  k_ff;          // tap
   logic [13:0] start_ff;      // pos*stride
   logic [SAW+1:0] srow_ff;    // ic*width
   logic [WAW+1:0] wrow_ff;    // (oc*IC+ic)*K
   logic        tap_vld_ff;
   logic [2:0]  drain_ff;
   logic        clear;

   logic [14:0] p_now;
   logic [14:0] col_now;
   logic        in_range;
   logic [SAW+1:0] s_addr;
   logic [WAW+1:0] w_addr;
   logic signed [43:0] acc;
   logic signed [43:0] rnd;
   logic signed [39:0] q;
   rsp_type_t_type rsp_ff;
   logic        rsp_vld_ff;

   assign padded = 10'(width_ff) + {5'd0, pad_ff, 1'b0};
   assign cfg_bad = (ic_ff == 4'd0) || (32'(ic_ff) > MAX_IN_CHANNELS) ||
                    (width_ff == 9'd0) || (32'(width_ff) > MAX_WIDTH) ||
                    (oc_ff == 4'd0) || (32'(oc_ff) > MAX_OUT_CHANNELS) ||
                    (taps_ff == 5'd0) || (32'(taps_ff) > MAX_KERNEL) ||
                    (step_ff == 4'd0) || (10'(taps_ff) > padded);

   assign p_now   = 15'(start_ff) + 15'(k_ff);
   assign col_now = p_now - 15'(pad_ff);
   assign in_range = (p_now >= 15'(pad_ff)) && (col_now < 15'(width_ff));
   assign s_addr = srow_ff + (SAW+2)'(col_now);
   assign w_addr = wrow_ff + (WAW+2)'(k_ff);
   assign clear = (state_ff == S_CHK);

   assign req.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff <= req.payload;
         conv_ff <= half_to_q412(req.payload.half_bits);
      end
      if (load_ff) begin
         unique case (item_ff.req_type)
            REQ_SAMPLE:
               if (32'(item_ff.load_index) < SDEPTH)
                  sample_mem[SAW'(item_ff.load_index)] <= item_ff.sample_value;
            REQ_WEIGHT:
               if (32'(item_ff.load_index) < WDEPTH)
                  weight_mem[WAW'(item_ff.load_index)] <= conv_ff;
            REQ_BIAS:
               if (32'(item_ff.load_index) < MAX_OUT_CHANNELS)
                  bias_mem[BAW'(item_ff.load_index)] <= conv_ff;
            default: ;
         endcase
      end
      s_rd_ff <= sample_mem[SAW'(s_addr)];
      w_rd_ff <= weight_mem[WAW'(w_addr)];
      b_rd_ff <= bias_mem[BAW'(item_ff.want_channel)];
   end

   c1dhw_mac u_mac (
      .clock    (clock),
      .clear    (clear),
      .bias_add (state_ff == S_FIN && bias_en_ff &&
                 32'(item_ff.want_channel) < MAX_OUT_CHANNELS),
      .tap_add  (tap_vld_ff),
      .a_value  (s_rd_ff),
      .b_value  (tap_vld_ff ? w_rd_ff : b_rd_ff),
      .acc_value(acc)
   );

   assign rnd = acc + 44'sd8;
   assign q = 40'(rnd >>> 4);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req.valid && req.ready)
                     state_in = (req.payload.req_type == REQ_COMPUTE) ? S_DIV : S_IDLE;
         S_DIV:   state_in = cfg_bad ? S_OUT : S_CHK;
         S_CHK:   if (rem_ff >= 10'(step_ff)) state_in = S_CHK;
                  else if (stat_ff != ST_OK ||
                           4'(item_ff.want_channel) >= oc_ff ||
                           10'(item_ff.want_position) > prod_ff) state_in = S_OUT;
                  else state_in = S_TAP;
         S_TAP:   if (ci_ff == ic_ff - 4'd1 && k_ff == taps_ff - 5'd1) state_in = S_DRAIN;
         S_DRAIN: if (drain_ff == 3'd3) state_in = S_BIAS;
         S_BIAS:  state_in = S_FIN;
         S_FIN:   state_in = S_OUT;
         S_OUT:   if (!rsp_vld_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_vld_ff <= 1'b0;
         load_ff <= 1'b0;
         tap_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ff <= req.valid && req.ready && req.payload.req_type != REQ_COMPUTE;
         tap_vld_ff <= (state_ff == S_TAP) && in_range;
         if (rsp.valid && rsp.ready) rsp_vld_ff <= 1'b0;
         if (state_ff == S_OUT && !rsp_vld_ff) rsp_vld_ff <= 1'b1;
      end
   end

   // produced width = span/stride + 1, one subtract per cycle in S_CHK;
   // prod_ff counts quotient, compare uses position > quotient
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_DIV: begin
            rem_ff <= padded - 10'(taps_ff);
            prod_ff <= 10'd0;
            stat_ff <= cfg_bad ? ST_CFG : ST_OK;
            ci_ff <= 4'd0;
            k_ff <= 5'd0;
            start_ff <= 14'(item_ff.want_position) * 14'(step_ff);
            srow_ff <= '0;
            wrow_ff <= (WAW+2)'(14'(item_ff.want_channel) * 14'(ic_ff) * 14'(taps_ff));
            drain_ff <= 3'd0;
         end
         S_CHK: if (rem_ff >= 10'(step_ff)) begin
            rem_ff <= rem_ff - 10'(step_ff);
            prod_ff <= prod_ff + 10'd1;
         end else if (stat_ff == ST_OK &&
                      (4'(item_ff.want_channel) >= oc_ff ||
                       10'(item_ff.want_position) > prod_ff)) begin
            stat_ff <= ST_RANGE;
         end
         S_TAP: begin
            if (k_ff == taps_ff - 5'd1) begin
               k_ff <= 5'd0;
               ci_ff <= ci_ff + 4'd1;
               srow_ff <= srow_ff + (SAW+2)'(width_ff);
               wrow_ff <= wrow_ff + (WAW+2)'(taps_ff);
            end else begin
               k_ff <= k_ff + 5'd1;
            end
         end
         S_DRAIN: drain_ff <= drain_ff + 3'd1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && !rsp_vld_ff) begin
         rsp_ff.status <= stat_ff;
         rsp_ff.out_count <= (stat_ff == ST_CFG) ? 9'd0 : 9'(prod_ff + 10'd1);
         if (stat_ff != ST_OK) rsp_ff.result_value <= 32'sd0;
         else if (q > 40'sh007FFFFFFF) rsp_ff.result_value <= 32'sh7FFFFFFF;
         else if (q < -40'sh0080000000) rsp_ff.result_value <= 32'sh80000000;
         else rsp_ff.result_value <= 32'(q);
      end
   end

   assign rsp.valid = rsp_vld_ff;
   assign rsp.payload = rsp_ff;
endmodule

@@ tb/c1dhw_checker.sv @@
module c1dhw_checker (
   input  logic       clock,
   input  logic       reset,
   c1dhw_req_if       req,
   c1dhw_rsp_if       rsp,
   input  logic       csr_write,
   input  logic [2:0] csr_index,
   input  logic [8:0] csr_data,
   output int         outstanding,
   output int         mismatches
);
   import c1dhw_pkg::*;

   logic [15:0] samples [0:2047];
   logic [15:0] weights [0:1023];
   logic [15:0] biases [0:7];

   logic [3:0] n_in_ch;
   logic [8:0] n_width;
   logic [3:0] n_out_ch;
   logic [4:0] n_taps;
   logic [3:0] stride;
   logic [3:0] pad;
   logic       bias_on;

   rsp_type_t_type pending_rsp[$];

   assign outstanding = pending_rsp.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
      mismatches++;
   endtask

   // binary16 -> Q4.12, ties away from zero, clamped to the 16-bit range
   function automatic logic [15:0] q412_from_half(input logic [15:0] h);
      longint ex, sig, scale, mag, v;
      ex = h[14:10];
      if (ex == 31) begin
         if (h[9:0] != 0) return 16'd0;
         mag = 65536;
      end else begin
         sig = (ex != 0) ? (h[9:0] + 1024) : h[9:0];
         scale = (ex != 0) ? ex : 1;
         if (scale >= 13) mag = sig << (scale - 13);
         else mag = (sig + (64'sd1 << (12 - scale))) >> (13 - scale);
      end
      if (h[15]) begin
         if (mag > 32768) mag = 32768;
         v = -mag;
      end else begin
         if (mag > 32767) mag = 32767;
         v = mag;
      end
      return v[15:0];
   endfunction

   function automatic rsp_type_t_type conv_output(input logic [2:0] oc, input logic [8:0] pos);
      rsp_type_t_type r;
      longint padded, produced, acc, p, col, res;
      padded = n_width + 2 * pad;
      r = '0;
      if (n_in_ch < 1 || n_in_ch > 8 || n_width < 1 || n_width > 256 ||
          n_out_ch < 1 || n_out_ch > 8 || n_taps < 1 || n_taps > 16 ||
          stride == 0 || n_taps > padded) begin
         r.status = ST_CFG;
         return r;
      end
      produced = (padded - n_taps) / stride + 1;
      r.out_count = produced[8:0];
      if (oc >= n_out_ch || pos >= produced) begin
         r.status = ST_RANGE;
         return r;
      end
      acc = 0;
      for (int ic = 0; ic < n_in_ch; ic++) begin
         for (int k = 0; k < n_taps; k++) begin
            p = pos * stride + k;
            if (p < pad || p - pad >= n_width) continue;
            col = p - pad;
            acc += longint'($signed(samples[ic * n_width + col])) *
                   longint'($signed(weights[(oc * n_in_ch + ic) * n_taps + k]));
         end
      end
      if (bias_on) acc += longint'($signed(biases[oc])) * 256;
      res = (acc + 8) >>> 4;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      r.result_value = res[31:0];
      r.status = ST_OK;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         n_in_ch <= 4'd1;
         n_width <= 9'd1;
         n_out_ch <= 4'd1;
         n_taps <= 5'd1;
         stride <= 4'd1;
         pad <= 4'd0;
         bias_on <= 1'b0;
         pending_rsp.delete();
         mismatches = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_IN_CHANNELS: n_in_ch <= csr_data[3:0];
               CSR_IN_WIDTH: n_width <= csr_data;
               CSR_OUT_CHANNELS: n_out_ch <= csr_data[3:0];
               CSR_KERNEL_TAPS: n_taps <= csr_data[4:0];
               CSR_STEP_SIZE: stride <= csr_data[3:0];
               CSR_PAD_AMOUNT: pad <= csr_data[3:0];
               CSR_BIAS_ENABLE: bias_on <= csr_data[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            case (req.payload.req_type)
               REQ_SAMPLE: samples[req.payload.load_index] = req.payload.sample_value;
               REQ_WEIGHT:
                  if (req.payload.load_index < 1024)
                     weights[req.payload.load_index] = q412_from_half(req.payload.half_bits);
               REQ_BIAS:
                  if (req.payload.load_index < 8)
                     biases[req.payload.load_index] = q412_from_half(req.payload.half_bits);
               default:
                  pending_rsp.push_back(conv_output(req.payload.want_channel,
                                                    req.payload.want_position));
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t unexpected result item", $time);
               mismatches++;
            end else begin
               rsp_type_t_type w;
               w = pending_rsp.pop_front();
               if (rsp.payload.result_value !== w.result_value)
                  report("result_value", rsp.payload.result_value, w.result_value);
               if (rsp.payload.out_count !== w.out_count)
                  report("out_count", rsp.payload.out_count, w.out_count);
               if (rsp.payload.status !== w.status)
                  report("status", rsp.payload.status, w.status);
            end
         end
      end
   end

endmodule

@@ tb/tb.sv @@
module tb;
   import c1dhw_pkg::*;

   typedef struct {
      int ic, w, oc, k, s, p, b;
   } conv_cfg_type;

   logic       clock;
   logic       reset;
   logic       csr_write;
   logic [2:0] csr_index;
   logic [8:0] csr_data;
   int         outstanding, mismatches;
   int         idle_cycles;
   int         item_count;
   int         rsp_stall;
   conv_cfg_type cur;
   conv_cfg_type settings[$];

   c1dhw_req_if req_ch();
   c1dhw_rsp_if rsp_ch();

   conv1d_half_weights_top i_dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   c1dhw_checker i_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .outstanding(outstanding), .mismatches(mismatches)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // no idling during these stretches
   function automatic bit calm();
      return (item_count % 200) < 40;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm() || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         rsp_stall <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= 5000) begin
         $display("Regression FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic req_type_t_type mk(input logic [1:0] kind, input int idx,
                                         input int sval, input int hb,
                                         input int ch, input int pos);
      req_type_t_type it;
      it.req_type = kind;
      it.load_index = idx[10:0];
      it.sample_value = sval[15:0];
      it.half_bits = hb[15:0];
      it.want_channel = ch[2:0];
      it.want_position = pos[8:0];
      return it;
   endfunction

   function automatic int rand_half();
      if ($urandom_range(0, 1)) return $urandom_range(0, 65535);
      return ($urandom_range(0, 1) << 15) | ($urandom_range(0, 16) << 10) |
             $urandom_range(0, 1023);
   endfunction

   task automatic send(input req_type_t_type it);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.payload <= it;
      do @(posedge clock); while (!req_ch.ready);
      item_count++;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input conv_cfg_type c);
      int vals[7];
      vals = '{c.ic, c.w, c.oc, c.k, c.s, c.p, c.b};
      cur = c;
      for (int i = 0; i < 7; i++) begin
         csr_write <= 1'b1;
         csr_index <= i[2:0];
         csr_data <= vals[i][8:0];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int produced_of(input conv_cfg_type c);
      int padded;
      padded = c.w + 2 * c.p;
      if (c.ic < 1 || c.ic > 8 || c.w < 1 || c.w > 256 || c.oc < 1 || c.oc > 8 ||
          c.k < 1 || c.k > 16 || c.s == 0 || c.k > padded) return 0;
      return (padded - c.k) / c.s + 1;
   endfunction

   task automatic random_item();
      int r, pw;
      req_type_t_type it;
      r = $urandom_range(0, 99);
      it = mk(REQ_SAMPLE, $urandom_range(0, 2047), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 7), $urandom_range(0, 511));
      if (r < 45) begin
         it.req_type = REQ_COMPUTE;
         pw = produced_of(cur);
         if (pw > 0 && $urandom_range(0, 99) < 85) begin
            it.want_channel = 3'($urandom_range(0, cur.oc - 1));
            it.want_position = 9'($urandom_range(0, pw - 1));
         end
      end else begin
         it.req_type = (r < 70) ? REQ_SAMPLE : (r < 92) ? REQ_WEIGHT : REQ_BIAS;
         if (it.req_type != REQ_SAMPLE) it.half_bits = 16'(rand_half());
         // mostly indexes inside the live part of each store
         if ($urandom_range(0, 1) && produced_of(cur) > 0) begin
            case (it.req_type)
               REQ_SAMPLE: it.load_index = 11'($urandom_range(0, cur.ic * cur.w - 1));
               REQ_WEIGHT:
                  it.load_index = 11'($urandom_range(0, cur.oc * cur.ic * cur.k - 1));
               default: it.load_index = 11'($urandom_range(0, cur.oc - 1));
            endcase
         end
      end
      send(it);
   endtask

   initial begin
      conv_cfg_type c;
      int kmax, omax;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      item_count = 0;
      cur = '{1, 1, 1, 1, 1, 0, 0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every entry a valid setting can read is written before any compute:
      // settings keep ic*w and oc*ic*k within 256
      for (int i = 0; i < 256; i++) send(mk(REQ_SAMPLE, i, $urandom_range(0, 65535), 0, 0, 0));
      for (int i = 0; i < 256; i++) send(mk(REQ_WEIGHT, i, 0, rand_half(), 0, 0));
      for (int i = 0; i < 8; i++) send(mk(REQ_BIAS, i, 0, rand_half(), 0, 0));

      send(mk(REQ_SAMPLE, 0, 32767, 0, 0, 0));
      send(mk(REQ_WEIGHT, 0, 0, 16'h7C00, 0, 0));
      send(mk(REQ_COMPUTE, 0, 0, 0, 0, 0));
      send(mk(REQ_WEIGHT, 0, 0, 16'hFE00, 0, 0));
      send(mk(REQ_COMPUTE, 2047, 65535, 65535, 0, 0));
      send(mk(REQ_SAMPLE, 0, -32768, 0, 0, 0));
      send(mk(REQ_WEIGHT, 0, 0, 16'hFC00, 0, 0));
      send(mk(REQ_COMPUTE, 0, 0, 0, 0, 0));
      send(mk(REQ_WEIGHT, 0, 0, 16'h0001, 0, 0));
      send(mk(REQ_COMPUTE, 0, 0, 0, 0, 0));
      send(mk(REQ_WEIGHT, 0, 0, 16'h0C00, 0, 0));
      send(mk(REQ_COMPUTE, 0, 0, 0, 0, 0));
      send(mk(REQ_WEIGHT, 0, 0, 16'hC000, 0, 0));
      send(mk(REQ_COMPUTE, 0, 0, 0, 0, 0));
      send(mk(REQ_WEIGHT, 2047, 0, 16'h3C00, 0, 0));
      send(mk(REQ_BIAS, 2047, 0, 16'h3C00, 0, 0));
      send(mk(REQ_BIAS, 0, 0, 16'h7BFF, 0, 0));
      send(mk(REQ_SAMPLE, 2047, 256, 0, 0, 0));
      send(mk(REQ_COMPUTE, 0, 0, 0, 7, 0));
      send(mk(REQ_COMPUTE, 0, 0, 0, 0, 511));
      send(mk(REQ_COMPUTE, 0, 0, 0, 0, 1));

      settings = '{
         '{8, 32, 2, 16, 1, 15, 1}, '{1, 1, 1, 1, 15, 0, 0}, '{3, 20, 4, 5, 2, 2, 1},
         '{8, 16, 2, 16, 3, 15, 1}, '{2, 10, 3, 4, 0, 1, 0}, '{2, 3, 2, 16, 1, 1, 1},
         '{0, 10, 1, 1, 1, 0, 0}, '{9, 10, 1, 1, 1, 0, 0}, '{15, 511, 15, 31, 15, 15, 1},
         '{4, 0, 2, 3, 1, 1, 0}, '{4, 300, 2, 3, 1, 1, 0}, '{1, 8, 0, 2, 1, 0, 1},
         '{1, 8, 1, 0, 1, 0, 1}, '{2, 40, 2, 17, 1, 0, 1}, '{1, 256, 8, 16, 1, 15, 1}
      };
      for (int i = 0; i < 5; i++) begin
         c.ic = $urandom_range(1, 8);
         c.w = $urandom_range(1, 256 / c.ic);
         c.p = $urandom_range(0, 15);
         kmax = (c.w + 2 * c.p) > 16 ? 16 : c.w + 2 * c.p;
         c.k = $urandom_range(1, kmax);
         omax = 256 / (c.ic * c.k) > 8 ? 8 : 256 / (c.ic * c.k);
         c.oc = $urandom_range(1, omax);
         c.s = $urandom_range(1, 15);
         c.b = $urandom_range(0, 1);
         settings.push_back(c);
      end

      foreach (settings[i]) begin
         drain();
         configure(settings[i]);
         repeat (20) random_item();
      end
      drain();
      configure('{2, 12, 3, 3, 1, 1, 1});
      repeat (20) random_item();

      drain();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/c1dhw_pkg.sv
src/c1dhw_if.sv
src/c1dhw_mac.sv
src/conv1d_half_weights_top.sv
tb/c1dhw_checker.sv
tb/tb.sv
